@@ src/hcrp_pkg.sv @@
// Package with shared types, constants and the logistic table for the receptor potential block.
`default_nettype none

package hcrp_pkg;

   // Sizes of the block
   localparam int CHANNELS          = 64;
   localparam int SIGMOID_ENTRIES   = 256;
   localparam int RESTING_POTENTIAL = 0;
   localparam int REFERENCE_OFFSET  = 0;

   localparam int CHANNEL_W = 6;
   localparam int DATA_W    = 32;
   localparam int CH_ABITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SIG_ABITS = $clog2(SIGMOID_ENTRIES);
   localparam int ENTRY_W   = 3 * DATA_W;
   localparam int SERIES_TERMS = 16;

   // Register file layout
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_COUPLING_GAIN   = 3'd0,
      REG_CILIA_RETENTION = 3'd1,
      REG_SIGMOID_GAIN    = 3'd2,
      REG_SIGMOID_OFFSET  = 3'd3,
      REG_DRIVE_GAIN      = 3'd4,
      REG_POT_RETENTION   = 3'd5,
      REG_POT_BIAS        = 3'd6,
      REG_ENDO_POTENTIAL  = 3'd7
   } reg_index_type;

   localparam logic signed [DATA_W-1:0] ENDO_RESET = 32'sd214748365;

   typedef struct packed {
      logic signed [DATA_W-1:0] coupling_gain;
      logic signed [DATA_W-1:0] cilia_retention;
      logic signed [DATA_W-1:0] sigmoid_gain;
      logic signed [DATA_W-1:0] sigmoid_offset;
      logic signed [DATA_W-1:0] drive_gain;
      logic signed [DATA_W-1:0] potential_retention;
      logic signed [DATA_W-1:0] potential_bias;
      logic signed [DATA_W-1:0] endocochlear_potential;
   } cfg_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_CILIA,
      S_SIGMUL,
      S_LOOKUP,
      S_DRIVE,
      S_POT,
      S_COMMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic fetch;
      logic cilia;
      logic sigmul;
      logic lookup;
      logic drive;
      logic pot;
      logic commit;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic in_range;
      logic out_free;
   } status_type;

   // Saturate a wide signed value to 32 bits
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [39:0] val);
      logic signed [DATA_W-1:0] res;
      if (val > 40'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (val < -40'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = val[DATA_W-1:0];
      end
      return res;
   endfunction

   // Restoring division, used only while the constant table is built
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t) in Q.31 for t in Q.29: series of the eighth, then squared three times
   function automatic logic [63:0] exp_neg(input logic [63:0] t);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      logic [63:0]        prod;
      term = 64'd2147483648;
      sum  = 64'sd2147483648;
      for (int k = 1; k <= SERIES_TERMS; k++) begin
         prod = term * t;
         term = div_u64(prod >> 32, 64'(k));
         if (k % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      r = (sum < 0) ? 64'd0 : $unsigned(sum);
      for (int k = 0; k < 3; k++) begin
         r = (r * r) >> 31;
      end
      return r;
   endfunction

   // Logistic of z (Q.29) in units of 2^-31
   function automatic logic [63:0] logistic_q31(input logic signed [63:0] z);
      logic [63:0] t;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] res;
      t = (z >= 0) ? $unsigned(z) : $unsigned(-z);
      if (t > 64'h1_0000_0000) begin
         t = 64'h1_0000_0000;
      end
      e   = exp_neg(t);
      den = 64'd2147483648 + e;
      if (z >= 0) begin
         res = div_u64(64'h4000_0000_0000_0000, den);
      end else begin
         res = div_u64(e << 31, den);
      end
      return res;
   endfunction

   typedef logic [DATA_W-1:0] sig_table_type [SIGMOID_ENTRIES];

   // Each cell holds the logistic at the midpoint of its span of z
   function automatic sig_table_type build_sig_table();
      sig_table_type      tbl;
      logic [63:0]        num;
      logic signed [63:0] mid;
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         num    = (64'(2 * k + 1) << 32) >> SIG_ABITS;
         mid    = $signed(num) - 64'sh1_0000_0000;
         tbl[k] = DATA_W'(logistic_q31(mid));
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

@@ src/hcrp_if.sv @@
// Handshake interfaces for the sample channel and the result channel.
`default_nettype none

interface hcrp_req_if import hcrp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [CHANNEL_W-1:0]        channel;
   logic signed [DATA_W-1:0]    sample;
   logic                        restart;

   modport source (output valid, channel, sample, restart, input ready);
   modport sink   (input valid, channel, sample, restart, output ready);
endinterface

interface hcrp_rsp_if import hcrp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [CHANNEL_W-1:0]        out_channel;
   logic signed [DATA_W-1:0]    potential;

   modport source (output valid, out_channel, potential, input ready);
   modport sink   (input valid, out_channel, potential, output ready);
endinterface

`default_nettype wire

@@ src/hcrp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module hcrp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]                  wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [WIDTH-1:0]                       rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/hcrp_csr.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module hcrp_csr import hcrp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]            prdata,
   output logic                         pready,
   output cfg_type                      cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_COUPLING_GAIN:   cfg_in.coupling_gain          = pwdata;
            REG_CILIA_RETENTION: cfg_in.cilia_retention        = pwdata;
            REG_SIGMOID_GAIN:    cfg_in.sigmoid_gain           = pwdata;
            REG_SIGMOID_OFFSET:  cfg_in.sigmoid_offset         = pwdata;
            REG_DRIVE_GAIN:      cfg_in.drive_gain             = pwdata;
            REG_POT_RETENTION:   cfg_in.potential_retention    = pwdata;
            REG_POT_BIAS:        cfg_in.potential_bias         = pwdata;
            REG_ENDO_POTENTIAL:  cfg_in.endocochlear_potential = pwdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{default: '0, endocochlear_potential: ENDO_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read mux
   always_comb begin
      case (index)
         REG_COUPLING_GAIN:   prdata = cfg_ff.coupling_gain;
         REG_CILIA_RETENTION: prdata = cfg_ff.cilia_retention;
         REG_SIGMOID_GAIN:    prdata = cfg_ff.sigmoid_gain;
         REG_SIGMOID_OFFSET:  prdata = cfg_ff.sigmoid_offset;
         REG_DRIVE_GAIN:      prdata = cfg_ff.drive_gain;
         REG_POT_RETENTION:   prdata = cfg_ff.potential_retention;
         REG_POT_BIAS:        prdata = cfg_ff.potential_bias;
         REG_ENDO_POTENTIAL:  prdata = cfg_ff.endocochlear_potential;
         default:             prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ src/hcrp_ctrl.sv @@
// Controller state machine that steps one sample through the datapath.
`default_nettype none

module hcrp_ctrl import hcrp_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_FETCH;
         S_FETCH:  state_in = status.in_range ? S_CILIA : S_COMMIT;
         S_CILIA:  state_in = S_SIGMUL;
         S_SIGMUL: state_in = S_LOOKUP;
         S_LOOKUP: state_in = S_DRIVE;
         S_DRIVE:  state_in = S_POT;
         S_POT:    state_in = S_COMMIT;
         S_COMMIT: if (status.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_FETCH:  cmd.fetch  = 1'b1;
         S_CILIA:  cmd.cilia  = 1'b1;
         S_SIGMUL: cmd.sigmul = 1'b1;
         S_LOOKUP: cmd.lookup = 1'b1;
         S_DRIVE:  cmd.drive  = 1'b1;
         S_POT:    cmd.pot    = 1'b1;
         S_COMMIT: cmd.commit = status.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ src/hcrp_datapath.sv @@
// Datapath: channel state store, cilia and potential updates, logistic lookup, result register.
`default_nettype none

module hcrp_datapath import hcrp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  cfg_type              cfg,
   input  cmd_type              cmd,
   output status_type           status,
   hcrp_req_if.sink             req_bus,
   hcrp_rsp_if.source           rsp_bus
);

   // Captured transaction
   logic [CHANNEL_W-1:0]     ch_ff;
   logic signed [DATA_W-1:0] x_ff;
   logic                     restart_ff;

   // Working registers
   logic signed [DATA_W-1:0] v_ff;
   logic signed [63:0]       p1_ff;
   logic signed [64:0]       p2_ff;
   logic signed [DATA_W-1:0] u_ff;
   logic signed [63:0]       q_ff;
   logic signed [63:0]       pv_ff;
   logic signed [32:0]       dv_ff;
   logic [DATA_W-1:0]        s_ff;
   logic signed [33:0]       d_ff;
   logic signed [66:0]       m_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic [CHANNEL_W-1:0]     rsp_ch_ff;
   logic signed [DATA_W-1:0] rsp_pot_ff;

   // Per-channel valid bits; an invalid entry reads as rest
   logic valid_ff [CHANNELS];

   logic [CH_ABITS-1:0]      rd_addr;
   logic [CH_ABITS-1:0]      ch_addr;
   logic [ENTRY_W-1:0]       rd_data;
   logic [ENTRY_W-1:0]       wr_data;
   logic                     wr_en;
   logic                     entry_ok;
   logic signed [DATA_W-1:0] prev_rd;
   logic signed [DATA_W-1:0] u_rd;
   logic signed [DATA_W-1:0] v_rd;
   logic signed [32:0]       diff;
   logic signed [36:0]       u_sum;
   logic signed [33:0]       z;
   logic [32:0]              z_off;
   logic [DATA_W-1:0]        s_in;
   logic signed [64:0]       d_prod;
   logic signed [39:0]       v_sum;
   logic signed [DATA_W-1:0] v_new;
   logic signed [DATA_W-1:0] res;
   logic                     in_range;

   assign ch_addr  = CH_ABITS'(ch_ff);
   assign rd_addr  = cmd.capture ? CH_ABITS'(req_bus.channel) : ch_addr;
   assign in_range = (32'(ch_ff) < CHANNELS);

   assign status.in_range = in_range;
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;

   hcrp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (ch_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff      <= req_bus.channel;
         x_ff       <= req_bus.sample;
         restart_ff <= req_bus.restart;
      end
   end

   // Fetch channel state and form the two cilia products
   assign entry_ok = valid_ff[ch_addr] && !restart_ff;
   assign prev_rd  = entry_ok ? rd_data[3*DATA_W-1:2*DATA_W] : '0;
   assign u_rd     = entry_ok ? rd_data[2*DATA_W-1:DATA_W] : '0;
   assign v_rd     = entry_ok ? rd_data[DATA_W-1:0] : DATA_W'(RESTING_POTENTIAL);
   assign diff     = 33'(x_ff) - 33'(prev_rd);

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         p1_ff <= u_rd * cfg.cilia_retention;
         p2_ff <= diff * cfg.coupling_gain;
         v_ff  <= v_rd;
      end
   end

   // New cilia displacement
   assign u_sum = 37'($signed(p1_ff[63:29])) + 37'($signed(p2_ff[64:29]));

   always_ff @(posedge clock) begin
      if (cmd.cilia) begin
         u_ff <= sat32(40'(u_sum));
      end
   end

   // Logistic argument product, retained potential and distance to Et
   always_ff @(posedge clock) begin
      if (cmd.sigmul) begin
         q_ff  <= cfg.sigmoid_gain * u_ff;
         pv_ff <= v_ff * cfg.potential_retention;
         dv_ff <= 33'(v_ff) - 33'(cfg.endocochlear_potential);
      end
   end

   // Logistic table lookup, saturating outside the table span
   assign z     = 34'($signed(q_ff[63:31])) + 34'(cfg.sigmoid_offset);
   assign z_off = 33'(z + 34'sh1_0000_0000);

   always_comb begin
      if (z < -34'sh1_0000_0000) begin
         s_in = '0;
      end else if (z >= 34'sh1_0000_0000) begin
         s_in = 32'h8000_0000;
      end else begin
         s_in = SIG_TABLE[z_off[32 -: SIG_ABITS]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         s_ff <= s_in;
      end
   end

   // Conductance drive
   assign d_prod = cfg.drive_gain * $signed({1'b0, s_ff});

   always_ff @(posedge clock) begin
      if (cmd.drive) begin
         d_ff <= $signed(d_prod[64:31]);
      end
   end

   // Drive times distance to Et
   always_ff @(posedge clock) begin
      if (cmd.pot) begin
         m_ff <= d_ff * dv_ff;
      end
   end

   // New potential and result
   assign v_sum = 40'($signed(pv_ff[63:29])) - 40'($signed(m_ff[66:29]))
                + 40'(cfg.potential_bias);
   assign v_new = sat32(v_sum);
   assign res   = sat32(40'(v_new) + 40'(REFERENCE_OFFSET));
   assign wr_en   = cmd.commit && in_range;
   assign wr_data = {x_ff, u_ff, v_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (wr_en) begin
         valid_ff[ch_addr] <= 1'b1;
      end
   end

   // Output register: holds a transaction until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ch_ff  <= ch_ff;
         rsp_pot_ff <= in_range ? res : '0;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_ch_ff;
   assign rsp_bus.potential   = rsp_pot_ff;

endmodule

`default_nettype wire

@@ src/hair_cell_receptor_potential_top.sv @@
// Top level of the inner hair cell receptor potential block.
//
// Usage. Samples arrive on req_bus (valid/ready): a channel number, a
// displacement sample and a restart flag. Each transaction yields exactly one
// result on rsp_bus (valid/ready) carrying the channel and the new receptor
// potential plus the reference, saturated to 32 bits.
// Coefficients must be written through the APB-style port only while the
// block idles; the block does not enforce it. A sample passes the fetch,
// cilia, sigmoid multiply, lookup, drive, potential and commit states, or
// fetch and commit only for a channel outside the store; this chain is set
// by four dependent multiplies, the state store read and the logistic table
// lookup. It takes one sample at a time, the next once a result is loaded.
// Reset clears the registers to their defaults and puts every channel at rest
// at once through per-channel valid bits; no clearing pass is needed.
// When the receiver stalls, the result waits in the output register and the
// controller holds its last step until that register is free.
`default_nettype none

module hair_cell_receptor_potential_top import hcrp_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   hcrp_req_if.sink                     req_bus,
   hcrp_rsp_if.source                   rsp_bus,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]            prdata,
   output logic                         pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       ready;

   // The controller decides when a sample transaction is taken
   assign req_bus.ready = ready;

   hcrp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hcrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   hcrp_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .status  (status),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire
